// File: sv/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 8;

    // Operation codes; the three codes above OP_LIST are ignored.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_REAR  = 3'd3,
        OP_LIST      = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    // Per-cycle command to every cell of a chain.
    typedef enum logic [2:0] {
        CC_HOLD = 3'd0,  // keep the word
        CC_PUSH = 3'd1,  // take the left neighbor (cell 0 takes the broadcast word)
        CC_POP  = 3'd2,  // take the right neighbor
        CC_PUT  = 3'd3,  // the cell at position count takes the broadcast word
        CC_ROT  = 3'd4   // pop, and the cell at position count-1 takes the broadcast word
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

`default_nettype wire

// File: sv/circular_deque_core.sv
// Double-ended queue of signed 32-bit words, DEPTH entries deep.
//
// Input channel (i_in_valid / o_in_ready): one transaction carries an
// operation code and a word. Codes: insert front, insert rear, remove front,
// remove rear, list. Codes 5..7 are taken and dropped without a result.
// Output channel (o_out_valid / i_out_ready): one transaction per result,
// with status, word, last-of-run flag and occupancy after the operation.
//
// An insert or remove result appears in the output register in the
// cycle after its transaction is taken. Inserts and removes sustain one
// transaction per cycle while the receiver keeps taking results.
// A list of n held words gives one word per cycle while the receiver keeps
// taking results, read from the front cell while the front chain rotates by
// one. The input channel is closed until the last word is loaded. An empty
// list gives a single result with the empty status.
//
// Reset leaves the deque empty and the output register empty; the word
// cells are not cleared. A stalled receiver holds the output register, and
// the input side closes until the register can be refilled.
`default_nettype none

module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [cdq_pkg::OP_W-1:0]             i_operation,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    i_element,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [cdq_pkg::STAT_W-1:0]                o_status,
    output logic signed [cdq_pkg::DATA_W-1:0]         o_word_out,
    output logic                                      o_last_of_run,
    output logic [$clog2(DEPTH+1)-1:0]                o_occupancy
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    // Two chains hold the same words: the front chain has the front word in
    // cell 0, the rear chain has the rear word in cell 0. Each end is then read
    // at cell 0 and every update is a shift, a write at cell count or a rotation.
    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_left;
    logic [CW-1:0]            n_left;

    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_word;
    logic                     r_last;
    logic [CW-1:0]            r_occ;

    logic                     w_slot_free;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;

    t_cell_cmd                w_a_cmd;
    t_cell_cmd                w_b_cmd;
    logic signed [DATA_W-1:0] w_a_bcast;
    logic signed [DATA_W-1:0] w_a_head;
    logic signed [DATA_W-1:0] w_b_head;

    logic                     w_load;
    t_status                  w_status;
    logic signed [DATA_W-1:0] w_word;
    logic                     w_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);

    // Next state: enter the listing run on a list of a non-empty deque,
    // leave it after the last word goes out.
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_LIST) && !w_empty) begin
                    n_state = S_LIST;
                    n_left  = r_count;
                end
            end
            S_LIST: begin
                if (w_slot_free) begin
                    n_left = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Chain commands and the result to load.
    always_comb begin
        w_a_cmd   = CC_HOLD;
        w_b_cmd   = CC_HOLD;
        w_a_bcast = i_element;
        n_count   = r_count;
        w_load    = 1'b0;
        w_status  = STAT_OK;
        w_word    = '0;
        w_last    = 1'b1;
        if (w_accept) begin
            case (i_operation)
                OP_INS_FRONT: begin
                    w_load = 1'b1;
                    if (w_full) begin
                        w_status = STAT_OVERFLOW;
                    end else begin
                        w_a_cmd = CC_PUSH;
                        w_b_cmd = CC_PUT;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_INS_REAR: begin
                    w_load = 1'b1;
                    if (w_full) begin
                        w_status = STAT_OVERFLOW;
                    end else begin
                        w_a_cmd = CC_PUT;
                        w_b_cmd = CC_PUSH;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_REM_FRONT: begin
                    w_load = 1'b1;
                    if (w_empty) begin
                        w_status = STAT_UNDERFLOW;
                    end else begin
                        w_word  = w_a_head;
                        w_a_cmd = CC_POP;
                        n_count = r_count - CW'(1);
                    end
                end
                OP_REM_REAR: begin
                    w_load = 1'b1;
                    if (w_empty) begin
                        w_status = STAT_UNDERFLOW;
                    end else begin
                        w_word  = w_b_head;
                        w_b_cmd = CC_POP;
                        n_count = r_count - CW'(1);
                    end
                end
                OP_LIST: begin
                    // A non-empty list is emitted from the listing state.
                    if (w_empty) begin
                        w_load   = 1'b1;
                        w_status = STAT_EMPTY;
                    end
                end
                default: begin
                    w_load = 1'b0;
                end
            endcase
        end else if ((r_state == S_LIST) && w_slot_free) begin
            // Emit the front word and rotate it to the rear of the front chain.
            w_a_cmd   = CC_ROT;
            w_a_bcast = w_a_head;
            w_load    = 1'b1;
            w_word    = w_a_head;
            w_last    = (r_left == CW'(1));
        end
    end

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_cmd   (w_a_cmd),
        .i_count (r_count),
        .i_bcast (w_a_bcast),
        .o_head  (w_a_head)
    );

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_rear (
        .i_clk   (i_clk),
        .i_cmd   (w_b_cmd),
        .i_count (r_count),
        .i_bcast (i_element),
        .o_head  (w_b_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold it while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_word   <= w_word;
            r_last   <= w_last;
            r_occ    <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_word_out    = r_word;
    assign o_last_of_run = r_last;
    assign o_occupancy   = r_occ;

    // Occupancy never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    // During a listing run the remaining count stays within the occupancy.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("listing count out of range");

    // A front insert that fits lands in the front cell.
    a_front_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_operation == OP_INS_FRONT) && !w_full)
        |=> (w_a_head == $past(i_element)))
        else $error("front insert not at front cell");

    // A rear insert that fits lands in the rear chain's head cell.
    a_rear_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_operation == OP_INS_REAR) && !w_full)
        |=> (w_b_head == $past(i_element)))
        else $error("rear insert not at rear cell");

endmodule

`default_nettype wire

// File: sv/cdq_cell.sv
`default_nettype none

module cdq_cell #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                                 i_clk,
    input  wire cdq_pkg::t_cell_cmd                   i_cmd,
    input  wire logic [$clog2(DEPTH+1)-1:0]           i_count,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    i_bcast,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    i_left,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    i_right,
    output logic signed [cdq_pkg::DATA_W-1:0]         o_word
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic signed [DATA_W-1:0] r_word;
    logic signed [DATA_W-1:0] n_word;
    logic                     w_at_count;
    logic                     w_at_last;

    assign w_at_count = (i_count == CW'(IDX));
    assign w_at_last  = (i_count == CW'(IDX + 1));

    always_comb begin
        case (i_cmd)
            CC_HOLD: n_word = r_word;
            CC_PUSH: n_word = i_left;
            CC_POP:  n_word = i_right;
            CC_PUT:  n_word = w_at_count ? i_bcast : r_word;
            CC_ROT:  n_word = w_at_last ? i_bcast : i_right;
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// File: sv/cdq_chain.sv
`default_nettype none

module cdq_chain #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire cdq_pkg::t_cell_cmd                   i_cmd,
    input  wire logic [$clog2(DEPTH+1)-1:0]           i_count,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]    i_bcast,
    output logic signed [cdq_pkg::DATA_W-1:0]         o_head
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] w_word [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = i_bcast;
        end else begin : g_inner_l
            assign w_left = w_word[k-1];
        end

        // Past the end nothing valid arrives; hold the own word.
        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_word[k];
        end else begin : g_inner_r
            assign w_right = w_word[k+1];
        end

        cdq_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_count (i_count),
            .i_bcast (i_bcast),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[k])
        );
    end

    assign o_head = w_word[0];

endmodule

`default_nettype wire

// File: tb/cdq_checker.sv
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [cdq_pkg::OP_W-1:0]             i_operation,
    input  logic signed [cdq_pkg::DATA_W-1:0]    i_element,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [cdq_pkg::STAT_W-1:0]           i_status,
    input  logic signed [cdq_pkg::DATA_W-1:0]    i_word_out,
    input  logic                                 i_last_of_run,
    input  logic [$clog2(DEPTH+1)-1:0]           i_occupancy,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output int                                   o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int OCC_W        = $clog2(DEPTH + 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        t_status                   status;
        logic signed [DATA_W-1:0]  word;
        logic                      last;
        logic [OCC_W-1:0]          occ;
    } t_deque_result;

    // Shadow copy of the deque.
    logic signed [DATA_W-1:0] slots [DEPTH];
    int                       front_slot;
    int                       rear_slot;
    bit                       deque_empty;

    t_deque_result pending_results [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
        front_slot   = 0;
        rear_slot    = 0;
        deque_empty  = 1'b1;
    end

    function automatic int held_words();
        if (deque_empty)
            return 0;
        return ((rear_slot + DEPTH - front_slot) % DEPTH) + 1;
    endfunction

    function automatic int slot_after(input int idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function automatic int slot_before(input int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    // Queue one result; occupancy is taken after the state update.
    task automatic push_result(input t_status st, input logic signed [DATA_W-1:0] w,
                               input logic last);
        t_deque_result r;
        r.status = st;
        r.word   = w;
        r.last   = last;
        r.occ    = OCC_W'(held_words());
        pending_results.push_back(r);
    endtask

    task automatic apply_deque_op(input logic [OP_W-1:0] op,
                                  input logic signed [DATA_W-1:0] elem);
        logic signed [DATA_W-1:0] taken;
        int                       n;
        int                       idx;
        case (op)
            OP_INS_FRONT, OP_INS_REAR: begin
                if (held_words() >= DEPTH) begin
                    push_result(STAT_OVERFLOW, '0, 1'b1);
                end else begin
                    if (deque_empty) begin
                        front_slot  = 0;
                        rear_slot   = 0;
                        deque_empty = 1'b0;
                        slots[0]    = elem;
                    end else if (op == OP_INS_FRONT) begin
                        front_slot        = slot_before(front_slot);
                        slots[front_slot] = elem;
                    end else begin
                        rear_slot        = slot_after(rear_slot);
                        slots[rear_slot] = elem;
                    end
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_REM_FRONT, OP_REM_REAR: begin
                if (deque_empty) begin
                    push_result(STAT_UNDERFLOW, '0, 1'b1);
                end else begin
                    taken = slots[(op == OP_REM_FRONT) ? front_slot : rear_slot];
                    if (front_slot == rear_slot) begin
                        deque_empty = 1'b1;
                        front_slot  = 0;
                        rear_slot   = 0;
                    end else if (op == OP_REM_FRONT) begin
                        front_slot = slot_after(front_slot);
                    end else begin
                        rear_slot = slot_before(rear_slot);
                    end
                    push_result(STAT_OK, taken, 1'b1);
                end
            end
            OP_LIST: begin
                if (deque_empty) begin
                    push_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    n   = held_words();
                    idx = front_slot;
                    for (int k = 0; k < n; k++) begin
                        push_result(STAT_OK, slots[idx], k == n - 1);
                        idx = slot_after(idx);
                    end
                end
            end
            default: begin
                // reserved codes: no result, no state change
            end
        endcase
    endtask

    task automatic check_result();
        t_deque_result want;
        o_results++;
        if (pending_results.size() == 0) begin
            if (o_mismatches < REPORT_LIMIT)
                $display("%t: unexpected result status=%0d word=%0d last=%0d occ=%0d",
                         $realtime, i_status, i_word_out, i_last_of_run, i_occupancy);
            o_mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (i_status !== want.status || i_word_out !== want.word ||
            i_last_of_run !== want.last || i_occupancy !== want.occ) begin
            if (o_mismatches < REPORT_LIMIT) begin
                $display("%t: result %0d mismatch:", $realtime, o_results);
                $display("  expected status=%0d word=%0d last=%0d occ=%0d",
                         want.status, want.word, want.last, want.occ);
                $display("  got      status=%0d word=%0d last=%0d occ=%0d",
                         i_status, i_word_out, i_last_of_run, i_occupancy);
            end
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot  = 0;
            rear_slot   = 0;
            deque_empty = 1'b1;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_deque_op(i_operation, i_element);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_pending = pending_results.size();
    end

endmodule

// File: tb/tb_circular_deque_core.sv
module tb_circular_deque_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH            = DEPTH_DEF;
    localparam int OCC_W            = $clog2(DEPTH + 1);
    localparam int ITEMS_PER_PHASE  = 105;
    localparam int BIAS_RUN         = 24;     // items before the insert/remove bias flips
    localparam int TAIL_CYCLES      = 20;     // settle time after the last result
    localparam int STUCK_LIMIT      = 4000;   // cycles without any transaction

    // Reserved operation codes, taken by the block and dropped.
    localparam logic [OP_W-1:0] OP_RSVD_LO = OP_W'(OP_LIST + 1);
    localparam logic [OP_W-1:0] OP_RSVD_HI = '1;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [OP_W-1:0]             i_operation;
    logic signed [DATA_W-1:0]    i_element;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [STAT_W-1:0]           o_status;
    logic signed [DATA_W-1:0]    o_word_out;
    logic                        o_last_of_run;
    logic [OCC_W-1:0]            o_occupancy;

    int mismatches;
    int pending;
    int results_checked;

    // Idle rates in percent, changed per phase by the stimulus.
    int send_idle_pct;
    int recv_stall_pct;

    int n_inserts;
    int n_removes;
    int n_lists;
    int n_reserved;
    int stuck_cycles;

    circular_deque_core #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_element     (i_element),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_word_out    (o_word_out),
        .o_last_of_run (o_last_of_run),
        .o_occupancy   (o_occupancy)
    );

    cdq_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_element     (i_element),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_word_out    (o_word_out),
        .i_last_of_run (o_last_of_run),
        .i_occupancy   (o_occupancy),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: drop ready at random at the falling edge, per the phase's stall rate.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when neither channel moves a transaction for too long.
    initial stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stuck_cycles, pending);
            $display("tb_circular_deque_core: FAIL");
            $finish;
        end
    end

    // Offer one transaction, called and returning at a falling edge. Idle cycles
    // come first so valid is never lowered and raised in the same time step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_element   <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        case (op)
            OP_INS_FRONT, OP_INS_REAR: n_inserts++;
            OP_REM_FRONT, OP_REM_REAR: n_removes++;
            OP_LIST:                   n_lists++;
            default:                   n_reserved++;
        endcase
    endtask

    // Hold the sender off until every expected result has been taken.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Mostly random words, with the extremes and the all-zero/all-one patterns mixed in.
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Lean toward inserts while filling and removes while draining, so runs
    // reach both the full and the empty deque often.
    function automatic logic [OP_W-1:0] pick_op(input bit filling);
        int unsigned roll;
        int unsigned ins_cut;
        roll    = $urandom_range(99);
        ins_cut = filling ? 55 : 25;
        if (roll < 4)
            return OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
        if (roll < 20)
            return OP_LIST;
        if (roll < 20 + ins_cut)
            return $urandom_range(1) ? OP_INS_REAR : OP_INS_FRONT;
        return $urandom_range(1) ? OP_REM_REAR : OP_REM_FRONT;
    endfunction

    initial begin
        bit filling;

        // Drive every input to a known value and hold reset.
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_INS_FRONT;
        i_element      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_inserts      = 0;
        n_removes      = 0;
        n_lists        = 0;
        n_reserved     = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: the empty deque first - empty list, underflow at both ends.
        send_item(OP_LIST,      '0);
        send_item(OP_REM_FRONT, '0);
        send_item(OP_REM_REAR,  '0);
        // Insert into an empty deque, then wrap the front below slot zero.
        send_item(OP_INS_REAR,  WORD_MAX);
        send_item(OP_INS_FRONT, WORD_MIN);
        send_item(OP_INS_REAR,  '1);
        send_item(OP_LIST,      '0);
        // Remove from both ends until the last word goes and the deque is empty again.
        send_item(OP_REM_REAR,  '0);
        send_item(OP_REM_FRONT, '0);
        send_item(OP_REM_FRONT, '0);
        // Fill to the brim from both ends with alternating bit patterns.
        for (int k = 0; k < DEPTH; k++)
            send_item((k % 2 == 1) ? OP_INS_REAR : OP_INS_FRONT,
                      (k % 4 == 0) ? 32'sh5555_5555 :
                      (k % 4 == 1) ? 32'shAAAA_AAAA :
                      (k % 4 == 2) ? WORD_MAX : WORD_MIN);
        // Overflow at both ends, a full listing, and the reserved codes.
        send_item(OP_INS_REAR,  $urandom);
        send_item(OP_INS_FRONT, $urandom);
        send_item(OP_LIST,      '0);
        send_item(OP_RSVD_LO,   $urandom);
        send_item(OP_RSVD_HI,   $urandom);
        send_item(OP_REM_REAR,  '0);
        send_item(OP_LIST,      '0);

        // Random phases: no idling, sender idle, receiver stalling, both.
        filling = 1'($urandom_range(1));
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % BIAS_RUN == 0)
                    filling = ~filling;
                send_item(pick_op(filling), pick_word());
                // Midway through the stalling phases, let the block run dry once.
                if (phase >= 2 && n == ITEMS_PER_PHASE / 2)
                    wait_for_drain();
            end
        end

        // Wait out every expected result, then a short tail for strays.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d inserts, %0d removes, %0d lists and %0d reserved codes;",
                 n_inserts, n_removes, n_lists, n_reserved);
        $display("  %0d results checked across four idle/stall phases, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_circular_deque_core: PASS");
        end else begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("tb_circular_deque_core: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/cdq_pkg.sv
sv/cdq_cell.sv
sv/cdq_chain.sv
sv/circular_deque_core.sv
tb/cdq_checker.sv
tb/tb_circular_deque_core.sv
